/* hdl/json_string_unescape_utf8_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/jsu_pkg.sv */
package jsu_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [20:0] CP_LIM1 = 21'h00080;
    localparam logic [20:0] CP_LIM2 = 21'h00800;
    localparam logic [20:0] CP_LIM3 = 21'h10000;
    localparam logic [20:0] CP_SUPP = 21'h10000;

    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    localparam int RES_DEPTH = 6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_HIGH,
        PH_HIGH_BS,
        PH_HEX2
    } phase_t;

    // Decoder state; the pending high surrogate keeps only its low ten bits.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_value;
        logic [1:0]  hex_count;
        logic        hex_stopped;
        logic [9:0]  pending;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       err;
    } res_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } enc_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic res_t mk_byte(input logic [7:0] d);
        res_t r;
        r.data  = d;
        r.valid = 1'b1;
        r.done  = 1'b0;
        r.err   = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_stat(input logic done, input logic err);
        res_t r;
        r.data  = 8'h00;
        r.valid = 1'b0;
        r.done  = done;
        r.err   = err;
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] m;
        m = c;
        unique case (c)
            CH_N:    m = 8'h0a;
            CH_R:    m = 8'h0d;
            CH_T:    m = 8'h09;
            CH_B:    m = 8'h08;
            CH_F:    m = 8'h0c;
            default: m = c;
        endcase
        return m;
    endfunction

    function automatic hex_t hex_dig(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end
        return h;
    endfunction

    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e.b   = '0;
        e.len = 3'd1;
        if (cp < CP_LIM1)
        begin
            e.b[0] = cp[7:0];
        end
        else if (cp < CP_LIM2)
        begin
            e.len  = 3'd2;
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < CP_LIM3)
        begin
            e.len  = 3'd3;
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            e.len  = 3'd4;
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

/* hdl/jsu_decode.sv */
module jsu_decode (
    input  logic [7:0]                          in_byte,
    input  logic                                start_req,
    input  jsu_pkg::dec_state_t                 state_cur,
    output jsu_pkg::dec_state_t                 state_nxt,
    output jsu_pkg::res_t [jsu_pkg::RES_DEPTH-1:0] res_list,
    output logic [2:0]                          res_cnt
);

    jsu_pkg::hex_t  hd;
    logic [15:0]    hv_upd;
    logic           st_upd;
    logic           hex_last;
    logic           v_high;
    logic           v_low;
    logic           is_quote;
    logic           is_bsl;
    logic           is_u;
    logic [20:0]    pair_cp;
    jsu_pkg::enc_t  enc_high;
    jsu_pkg::enc_t  enc_val;
    jsu_pkg::enc_t  enc_pair;
    logic           a_en;
    jsu_pkg::res_t [3:0] b_list;
    logic [2:0]     b_cnt;

    assign hd       = jsu_pkg::hex_dig(in_byte);
    assign hv_upd   = (!state_cur.hex_stopped && hd.ok) ?
                      {state_cur.hex_value[11:0], hd.val} : state_cur.hex_value;
    assign st_upd   = state_cur.hex_stopped | ~hd.ok;
    assign hex_last = (state_cur.hex_count == 2'd3);
    assign v_high   = (hv_upd[15:10] == jsu_pkg::SURR_HIGH);
    assign v_low    = (hv_upd[15:10] == jsu_pkg::SURR_LOW);
    assign is_quote = (in_byte == jsu_pkg::CH_QUOTE);
    assign is_bsl   = (in_byte == jsu_pkg::CH_BSL);
    assign is_u     = (in_byte == jsu_pkg::CH_U);
    assign pair_cp  = {1'b0, state_cur.pending, hv_upd[9:0]} + jsu_pkg::CP_SUPP;

    assign enc_high = jsu_pkg::utf8_enc({5'd0, jsu_pkg::SURR_HIGH, state_cur.pending});
    assign enc_val  = jsu_pkg::utf8_enc({5'd0, hv_upd});
    assign enc_pair = jsu_pkg::utf8_enc(pair_cp);

    // Next decoder state.
    always_comb
    begin
        state_nxt = state_cur;
        if (start_req)
        begin
            state_nxt       = '0;
            state_nxt.phase = is_quote ? jsu_pkg::PH_BODY : jsu_pkg::PH_IDLE;
        end
        else
        begin
            unique case (state_cur.phase)
                jsu_pkg::PH_BODY:
                begin
                    if (is_quote)
                        state_nxt.phase = jsu_pkg::PH_IDLE;
                    else if (is_bsl)
                        state_nxt.phase = jsu_pkg::PH_ESC;
                end
                jsu_pkg::PH_ESC:
                begin
                    if (is_u)
                    begin
                        state_nxt.hex_value   = '0;
                        state_nxt.hex_count   = '0;
                        state_nxt.hex_stopped = 1'b0;
                        state_nxt.phase       = jsu_pkg::PH_HEX1;
                    end
                    else
                        state_nxt.phase = jsu_pkg::PH_BODY;
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2:
                begin
                    if (is_quote)
                        state_nxt = '0;
                    else if (!hex_last)
                    begin
                        state_nxt.hex_value   = hv_upd;
                        state_nxt.hex_stopped = st_upd;
                        state_nxt.hex_count   = state_cur.hex_count + 2'd1;
                    end
                    else
                    begin
                        state_nxt.hex_value   = '0;
                        state_nxt.hex_count   = '0;
                        state_nxt.hex_stopped = 1'b0;
                        state_nxt.pending     = '0;
                        if (state_cur.phase == jsu_pkg::PH_HEX2 && v_low)
                            state_nxt.phase = jsu_pkg::PH_BODY;
                        else if (v_high)
                        begin
                            state_nxt.pending = hv_upd[9:0];
                            state_nxt.phase   = jsu_pkg::PH_HIGH;
                        end
                        else
                            state_nxt.phase = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_HIGH:
                begin
                    if (is_bsl)
                        state_nxt.phase = jsu_pkg::PH_HIGH_BS;
                    else
                    begin
                        state_nxt.pending = '0;
                        state_nxt.phase   = is_quote ? jsu_pkg::PH_IDLE : jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_HIGH_BS:
                begin
                    if (is_u)
                    begin
                        state_nxt.hex_value   = '0;
                        state_nxt.hex_count   = '0;
                        state_nxt.hex_stopped = 1'b0;
                        state_nxt.phase       = jsu_pkg::PH_HEX2;
                    end
                    else
                    begin
                        state_nxt.pending = '0;
                        state_nxt.phase   = jsu_pkg::PH_BODY;
                    end
                end
                default:
                    state_nxt.phase = jsu_pkg::PH_IDLE;
            endcase
        end
    end

    // Results of this byte: an optional flushed high surrogate, then the rest.
    always_comb
    begin
        a_en   = 1'b0;
        b_list = '0;
        b_cnt  = 3'd0;
        if (start_req)
        begin
            if (!is_quote)
            begin
                b_list[0] = jsu_pkg::mk_stat(1'b0, 1'b1);
                b_cnt     = 3'd1;
            end
        end
        else
        begin
            unique case (state_cur.phase)
                jsu_pkg::PH_BODY, jsu_pkg::PH_HIGH:
                begin
                    if (!(state_cur.phase == jsu_pkg::PH_HIGH && is_bsl))
                    begin
                        a_en = (state_cur.phase == jsu_pkg::PH_HIGH);
                        if (is_quote)
                        begin
                            b_list[0] = jsu_pkg::mk_stat(1'b1, 1'b0);
                            b_cnt     = 3'd1;
                        end
                        else if (!is_bsl)
                        begin
                            b_list[0] = jsu_pkg::mk_byte(in_byte);
                            b_cnt     = 3'd1;
                        end
                    end
                end
                jsu_pkg::PH_ESC, jsu_pkg::PH_HIGH_BS:
                begin
                    if (!is_u)
                    begin
                        a_en      = (state_cur.phase == jsu_pkg::PH_HIGH_BS);
                        b_list[0] = jsu_pkg::mk_byte(jsu_pkg::esc_map(in_byte));
                        b_cnt     = 3'd1;
                    end
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2:
                begin
                    if (is_quote)
                    begin
                        b_list[0] = jsu_pkg::mk_stat(1'b0, 1'b1);
                        b_cnt     = 3'd1;
                    end
                    else if (hex_last)
                    begin
                        if (state_cur.phase == jsu_pkg::PH_HEX2 && v_low)
                        begin
                            for (int i = 0; i < 4; i++)
                                b_list[i] = jsu_pkg::mk_byte(enc_pair.b[i]);
                            b_cnt = enc_pair.len;
                        end
                        else
                        begin
                            a_en = (state_cur.phase == jsu_pkg::PH_HEX2);
                            if (!v_high)
                            begin
                                for (int i = 0; i < 4; i++)
                                    b_list[i] = jsu_pkg::mk_byte(enc_val.b[i]);
                                b_cnt = enc_val.len;
                            end
                        end
                    end
                end
                default:
                begin
                    b_cnt = 3'd0;
                end
            endcase
        end
    end

    // Join the two parts; a flushed surrogate is always three bytes.
    always_comb
    begin
        res_list = '0;
        if (a_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_list[i]     = jsu_pkg::mk_byte(enc_high.b[i]);
                res_list[i + 3] = b_list[i];
            end
            res_cnt = 3'd3 + b_cnt;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                res_list[i] = b_list[i];
            res_cnt = b_cnt;
        end
    end

endmodule

/* hdl/json_string_unescape_utf8_top.sv */
// Channel  Direction  Handshake            Payload
// input    sink       in_valid / in_stall  in_byte, start_req
// output   source     out_valid/out_stall  out_byte, byte_valid, last, done_res, error
//
// Each input byte is decoded from the input register into a burst
// register holding up to six results; the burst drains one transfer per cycle
// while out_stall is low. A byte yields n results (n = 0..6), and the next byte is
// decoded in the same cycle the last result of a burst leaves.
// Reset (rst_n low, asynchronous) empties both registers and idles the decoder.
// out_stall backs up through the burst into in_stall within the same cycle.
module json_string_unescape_utf8_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       start_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last,
    output logic       done_res,
    output logic       error
);

    // Input register.
    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Decoder state.
    jsu_pkg::dec_state_t state_reg;
    jsu_pkg::dec_state_t state_next;

    // Result burst: entry zero faces the output port.
    jsu_pkg::res_t [jsu_pkg::RES_DEPTH-1:0] burst_reg;
    jsu_pkg::res_t [jsu_pkg::RES_DEPTH-1:0] burst_next;
    logic [2:0]                             cnt_reg;
    logic [2:0]                             cnt_next;

    jsu_pkg::res_t [jsu_pkg::RES_DEPTH-1:0] dec_list;
    logic [2:0]                             dec_cnt;
    jsu_pkg::dec_state_t                    dec_state;

    logic in_fire;
    logic out_fire;
    logic can_load;
    logic dec_fire;

    // Handshake: the burst may reload once it is empty or its final entry leaves.
    assign out_fire = (cnt_reg != 3'd0) && !out_stall;
    assign can_load = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_fire);
    assign dec_fire = in_full_reg && can_load;
    assign in_stall = in_full_reg && !can_load;
    assign in_fire  = in_valid && !in_stall;

    jsu_decode u_decode (
        .in_byte   (in_byte_reg),
        .start_req (in_start_reg),
        .state_cur (state_reg),
        .state_nxt (dec_state),
        .res_list  (dec_list),
        .res_cnt   (dec_cnt)
    );

    // Hold the input until it is decoded; a new transfer may land in the same cycle.
    always_comb
    begin
        if (in_fire)
            in_full_next = 1'b1;
        else if (dec_fire)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;
    end

    // Advance the decoder only on a decoded byte.
    always_comb
    begin
        state_next = dec_fire ? dec_state : state_reg;
    end

    // Load a new burst, or shift the current one by one on each output transfer.
    always_comb
    begin
        burst_next = burst_reg;
        cnt_next   = cnt_reg;
        if (dec_fire)
        begin
            burst_next = dec_list;
            cnt_next   = dec_cnt;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < jsu_pkg::RES_DEPTH - 1; i++)
                burst_next[i] = burst_reg[i + 1];
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= '0;
            cnt_reg     <= 3'd0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg  <= in_byte;
            in_start_reg <= start_req;
        end
        burst_reg <= burst_next;
    end

    assign out_valid  = (cnt_reg != 3'd0);
    assign out_byte   = burst_reg[0].data;
    assign byte_valid = burst_reg[0].valid;
    assign done_res   = burst_reg[0].done;
    assign error      = burst_reg[0].err;
    assign last       = (cnt_reg == 3'd1);

endmodule

/* hdl/jsu_checker.sv */
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       last,
    input logic       done_res,
    input logic       error
);

    logic [11:0] res_word;
    logic        out_held;
    logic        is_status;
    logic        empty_slot;

    assign res_word   = {out_byte, byte_valid, last, done_res, error};
    assign out_held   = out_valid && out_stall;
    assign is_status  = out_valid && (done_res || error);
    assign empty_slot = out_valid && !byte_valid;

    // A stalled result holds.
    `JSU_ASSERT(a_out_hold, out_held |=> out_valid && $stable(res_word), "stalled result moved")

    // Status results carry no byte and close the burst of their input.
    `JSU_ASSERT(a_stat_last, is_status |-> last && !byte_valid, "status result misplaced")

    // An empty slot reads as zero.
    `JSU_ASSERT(a_zero_byte, empty_slot |-> out_byte == 8'h00, "empty slot carries data")

    // Done and error never share a result.
    `JSU_ASSERT(a_excl, out_valid |-> !(done_res && error), "done and error together")

    // Nothing leaves while reset is held.
    `JSU_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "result during reset")

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);

/* dv/json_string_unescape_utf8_top_tb.sv */
`timescale 1ns / 100ps

// One decoded result as it leaves the block.
typedef struct {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       done_res;
    logic       error;
} utf8_res_t;

// Value of a hex digit character, or -1 for anything else.
function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39)
        return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66)
        return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46)
        return int'(c) - 'h41 + 10;
    return -1;
endfunction

// Tracks the unescape state of the string and holds the UTF-8 bytes still owed.
class unescape_board;
    jsu_pkg::phase_t phase;
    logic [15:0]     hex_val;
    int              hex_cnt;
    bit              hex_stop;
    logic [15:0]     high_half;
    utf8_res_t       burst[$];
    utf8_res_t       due[$];
    int              fails;

    function new();
        fails = 0;
        clear_all();
    endfunction

    function void clear_hex();
        hex_val  = '0;
        hex_cnt  = 0;
        hex_stop = 0;
    endfunction

    function void clear_all();
        phase     = jsu_pkg::PH_IDLE;
        high_half = '0;
        clear_hex();
    endfunction

    function void push_byte(logic [7:0] d);
        utf8_res_t r;
        r.out_byte   = d;
        r.byte_valid = 1'b1;
        r.last       = 1'b0;
        r.done_res   = 1'b0;
        r.error      = 1'b0;
        burst.push_back(r);
    endfunction

    function void push_status(logic done, logic err);
        utf8_res_t r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.last       = 1'b0;
        r.done_res   = done;
        r.error      = err;
        burst.push_back(r);
    endfunction

    function void push_cp(int cp);
        if (cp < 'h80)
            push_byte(8'(cp));
        else if (cp < 'h800)
        begin
            push_byte(8'('hc0 | (cp >> 6)));
            push_byte(8'('h80 | (cp & 'h3f)));
        end
        else if (cp < 'h10000)
        begin
            push_byte(8'('he0 | (cp >> 12)));
            push_byte(8'('h80 | ((cp >> 6) & 'h3f)));
            push_byte(8'('h80 | (cp & 'h3f)));
        end
        else
        begin
            push_byte(8'('hf0 | ((cp >> 18) & 7)));
            push_byte(8'('h80 | ((cp >> 12) & 'h3f)));
            push_byte(8'('h80 | ((cp >> 6) & 'h3f)));
            push_byte(8'('h80 | (cp & 'h3f)));
        end
    endfunction

    // Flush a held high surrogate on its own as three bytes.
    function void flush_high();
        push_cp(int'(high_half));
        high_half = '0;
    endfunction

    function void body_char(logic [7:0] b);
        if (b == jsu_pkg::CH_QUOTE)
        begin
            phase = jsu_pkg::PH_IDLE;
            push_status(1'b1, 1'b0);
        end
        else if (b == jsu_pkg::CH_BSL)
            phase = jsu_pkg::PH_ESC;
        else
            push_byte(b);
    endfunction

    function void escaped_char(logic [7:0] b);
        logic [7:0] c;
        c = b;
        phase = jsu_pkg::PH_BODY;
        case (b)
            jsu_pkg::CH_N: c = 8'h0a;
            jsu_pkg::CH_R: c = 8'h0d;
            jsu_pkg::CH_T: c = 8'h09;
            jsu_pkg::CH_B: c = 8'h08;
            jsu_pkg::CH_F: c = 8'h0c;
            jsu_pkg::CH_U:
            begin
                clear_hex();
                phase = jsu_pkg::PH_HEX1;
                return;
            end
            default: c = b;
        endcase
        push_byte(c);
    endfunction

    // A finished \u value with no high surrogate to pair with.
    function void single_value(logic [15:0] v);
        if (v >= 16'hd800 && v < 16'hdc00)
        begin
            high_half = v;
            phase     = jsu_pkg::PH_HIGH;
        end
        else
        begin
            phase = jsu_pkg::PH_BODY;
            push_cp(int'(v));
        end
    endfunction

    function void hex_char_in(logic [7:0] b);
        int          d;
        logic [15:0] v;
        int          cp;
        if (b == jsu_pkg::CH_QUOTE)
        begin
            clear_all();
            push_status(1'b0, 1'b1);
            return;
        end
        d = hex_nibble(b);
        if (!hex_stop && d >= 0)
            hex_val = {hex_val[11:0], 4'(d)};
        else
            hex_stop = 1;
        hex_cnt++;
        if (hex_cnt < 4)
            return;
        v = hex_val;
        clear_hex();
        if (phase == jsu_pkg::PH_HEX1)
            single_value(v);
        else if (v >= 16'hdc00 && v < 16'he000)
        begin
            cp = 'h10000 + ((int'(high_half) - 'hd800) << 10) + (int'(v) - 'hdc00);
            high_half = '0;
            phase     = jsu_pkg::PH_BODY;
            push_cp(cp);
        end
        else
        begin
            flush_high();
            single_value(v);
        end
    endfunction

    // Work out what one accepted input byte produces.
    function void note_byte(logic [7:0] b, logic s);
        burst.delete();
        if (s)
        begin
            clear_all();
            if (b == jsu_pkg::CH_QUOTE)
                phase = jsu_pkg::PH_BODY;
            else
                push_status(1'b0, 1'b1);
        end
        else
        begin
            case (phase)
                jsu_pkg::PH_BODY: body_char(b);
                jsu_pkg::PH_ESC:  escaped_char(b);
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: hex_char_in(b);
                jsu_pkg::PH_HIGH:
                begin
                    if (b == jsu_pkg::CH_BSL)
                        phase = jsu_pkg::PH_HIGH_BS;
                    else
                    begin
                        flush_high();
                        phase = jsu_pkg::PH_BODY;
                        body_char(b);
                    end
                end
                jsu_pkg::PH_HIGH_BS:
                begin
                    if (b == jsu_pkg::CH_U)
                    begin
                        clear_hex();
                        phase = jsu_pkg::PH_HEX2;
                    end
                    else
                    begin
                        flush_high();
                        escaped_char(b);
                    end
                end
                default: phase = jsu_pkg::PH_IDLE;
            endcase
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            due.push_back(burst[i]);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    function void check_out(logic [7:0] b, logic bv, logic lst, logic dn, logic err);
        utf8_res_t e;
        if (due.size() == 0)
        begin
            $error("unexpected result: out_byte %0h byte_valid %0b last %0b done_res %0b error %0b",
                   b, bv, lst, dn, err);
            fails++;
            return;
        end
        e = due.pop_front();
        cmp("out_byte", e.out_byte, b);
        cmp("byte_valid", e.byte_valid, bv);
        cmp("last", e.last, lst);
        cmp("done_res", e.done_res, dn);
        cmp("error", e.error, err);
    endfunction

    function int pending();
        return due.size();
    endfunction
endclass

module json_string_unescape_utf8_top_tb;

    // Cycles with no transfer on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 430;

    typedef struct {
        logic [7:0] b;
        logic       s;
    } feed_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       start_req = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       done_res;
    logic       error;

    int src_idle_pct = 26;
    int stall_pct = 70;
    int quiet_cycles = 0;

    unescape_board board;
    feed_t         feed[$];

    json_string_unescape_utf8_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .done_res   (done_res),
        .error      (error)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure: a fresh coin every cycle, none during reset.
    always @(posedge clk)
    begin
        out_stall <= rst_n ? ($urandom_range(99) < stall_pct) : 1'b0;
    end

    // Check every result transfer against the oldest byte still owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_out(out_byte, byte_valid, last, done_res, error);
    end

    // Watchdog: give up once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("json_string_unescape_utf8_top_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus building blocks
    // ---------------------------------------------------------------

    function automatic void put_feed(logic [7:0] b, logic s = 1'b0);
        feed_t f;
        f.b = b;
        f.s = s;
        feed.push_back(f);
    endfunction

    function automatic void put_text(string t);
        for (int i = 0; i < t.len(); i++)
            put_feed(t[i]);
    endfunction

    // Hex digit with a random letter case.
    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + v;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + (v - 4'd10);
    endfunction

    // Any byte that may stand bare in a string body.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == jsu_pkg::CH_QUOTE || hex_nibble(b) >= 0);
        return b;
    endfunction

    // Byte after a backslash, other than 'u': mostly the mapped letters.
    function automatic logic [7:0] escape_char();
        logic [7:0] b;
        if ($urandom_range(9) < 7)
        begin
            case ($urandom_range(4))
                0: b = jsu_pkg::CH_N;
                1: b = jsu_pkg::CH_R;
                2: b = jsu_pkg::CH_T;
                3: b = jsu_pkg::CH_B;
                default: b = jsu_pkg::CH_F;
            endcase
        end
        else
        begin
            do
                b = 8'($urandom_range(255));
            while (b == jsu_pkg::CH_U);
        end
        return b;
    endfunction

    // \u escape; stop_at >= 0 puts a non-hex byte in that position and
    // random filler after it.
    function automatic void put_u(int val, int stop_at = -1);
        put_feed(jsu_pkg::CH_BSL);
        put_feed(jsu_pkg::CH_U);
        for (int i = 0; i < 4; i++)
        begin
            if (i == stop_at)
                put_feed(non_hex_byte());
            else if (stop_at >= 0 && i > stop_at)
                put_feed($urandom_range(1) ? hex_char(4'($urandom_range(15))) : non_hex_byte());
            else
                put_feed(hex_char(4'(val >> (12 - 4 * i))));
        end
    endfunction

    // Code unit spread over the one-, two- and three-byte encodings, with the range edges.
    function automatic int rand_value();
        case ($urandom_range(4))
            0: return $urandom_range('h7f);
            1: return $urandom_range('h7ff, 'h80);
            2: return $urandom_range('hffff, 'h800);
            default:
            begin
                case ($urandom_range(11))
                    0:  return 'h0000;
                    1:  return 'h007f;
                    2:  return 'h0080;
                    3:  return 'h07ff;
                    4:  return 'h0800;
                    5:  return 'hffff;
                    6:  return 'hd7ff;
                    7:  return 'he000;
                    8:  return 'hd800;
                    9:  return 'hdbff;
                    10: return 'hdc00;
                    default: return 'hdfff;
                endcase
            end
        endcase
    endfunction

    function automatic int rand_high();
        case ($urandom_range(5))
            0: return 'hd800;
            1: return 'hdbff;
            default: return $urandom_range('hdbff, 'hd800);
        endcase
    endfunction

    function automatic int rand_low();
        case ($urandom_range(5))
            0: return 'hdc00;
            1: return 'hdfff;
            default: return $urandom_range('hdfff, 'hdc00);
        endcase
    endfunction

    function automatic void put_token();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            put_feed(plain_byte());
        else if (r < 50)
        begin
            put_feed(jsu_pkg::CH_BSL);
            put_feed(escape_char());
        end
        else if (r < 65)
            put_u(rand_value());
        else if (r < 78)
        begin
            // proper surrogate pair
            put_u(rand_high());
            put_u(rand_low());
        end
        else if (r < 88)
        begin
            // high surrogate followed by a plain byte, a short escape, another \u value or nothing
            put_u(rand_high());
            case ($urandom_range(3))
                0: put_feed(plain_byte());
                1:
                begin
                    put_feed(jsu_pkg::CH_BSL);
                    put_feed(escape_char());
                end
                2: put_u(rand_value(), $urandom_range(1) ? -1 : $urandom_range(3));
                default: ;
            endcase
        end
        else if (r < 94)
            put_u(rand_value(), $urandom_range(3));
        else
            put_u(rand_low());
    endfunction

    // One string, mostly well formed; returns the items before any noise.
    function automatic int build_string();
        int r;
        int n;
        put_feed(jsu_pkg::CH_QUOTE, 1'b1);
        repeat ($urandom_range(12, 1))
            put_token();
        r = $urandom_range(99);
        if (r < 78)
            put_feed(jsu_pkg::CH_QUOTE);
        else if (r < 86)
        begin
            // quote lands inside the hex positions
            put_feed(jsu_pkg::CH_BSL);
            put_feed(jsu_pkg::CH_U);
            repeat ($urandom_range(3))
                put_feed(hex_char(4'($urandom_range(15))));
            put_feed(jsu_pkg::CH_QUOTE);
        end
        else if (r < 93)
        begin
            // drop the string mid-way with a start lacking the quote
            put_feed(plain_byte(), 1'b1);
        end
        // otherwise leave it open: the next start restarts mid-string
        n = feed.size();
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(3, 1))
                put_feed(8'($urandom_range(255)));
        return n;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Present one byte, hold it through any stall, note it once taken.
    task automatic send_item(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        start_req <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_byte(b, s);
    endtask

    task automatic send_feed();
        feed_t f;
        while (feed.size() > 0)
        begin
            f = feed.pop_front();
            send_item(f.b, f.s);
        end
    endtask

    // Hold the input idle until every owed byte has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        rst_n <= 1'b0;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: idle byte ignored, start without a quote, byte
        // extremes, surrogate pair at the top of the code space, a high
        // surrogate left pending then dropped by a quote in the hex
        // positions, and a restart in the middle of a string.
        put_feed(8'h5a);
        put_feed(8'h41, 1'b1);
        put_feed(jsu_pkg::CH_QUOTE, 1'b1);
        put_feed(8'h00);
        put_feed(8'hff);
        put_text("\\uDBFF\\uDFFF\\uD800\\u");
        put_feed(jsu_pkg::CH_QUOTE);
        put_feed(jsu_pkg::CH_QUOTE, 1'b1);
        put_feed(8'h71);
        put_feed(jsu_pkg::CH_QUOTE, 1'b1);
        put_feed(jsu_pkg::CH_QUOTE);
        sent = feed.size();
        send_feed();

        // Random strings over three pacing regimes: slow receiver, slow
        // sender, then full rate. Drain fully at each switch.
        while (sent < ITEM_TARGET)
        begin
            if (sent >= 290 && src_idle_pct != 0)
            begin
                drain_results();
                src_idle_pct = 0;
                stall_pct    = 0;
            end
            else if (sent >= 150 && src_idle_pct == 26)
            begin
                drain_results();
                src_idle_pct = 70;
                stall_pct    = 26;
            end
            sent += build_string();
            send_feed();
            if ($urandom_range(19) == 0)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("json_string_unescape_utf8_top_tb OK");
        else
            $display("json_string_unescape_utf8_top_tb NOT OK");
        $finish;
    end

endmodule
